// ===== hw/rtl/threshold_keyed_rank_sorter_top_macros.svh =====
// assertion macros for the rank sorter checker
`ifndef THRESHOLD_KEYED_RANK_SORTER_TOP_MACROS_SVH
`define THRESHOLD_KEYED_RANK_SORTER_TOP_MACROS_SVH

// implication in the same cycle, disabled in reset
`define TKRS_ASSERT_IMPL(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
        else $error("tkrs assertion failed");

// implication into the next cycle, disabled in reset
`define TKRS_ASSERT_NEXT(name, clk, rst_n, a, c) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
        else $error("tkrs assertion failed");

// implication into the next cycle, always checked
`define TKRS_ASSERT_ALWAYS_NEXT(name, clk, a, c) \
    name: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("tkrs assertion failed");

`endif

// ===== hw/rtl/tkrs_pkg.sv =====
package tkrs_pkg;

    // command codes
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    // error codes
    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_RANK = 2'd1;
    localparam logic [1:0] ERR_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] primary_key;
        logic [31:0] second_key;
        logic [31:0] third_key;
        logic [10:0] rank_asked;
    } t_in_item;

    typedef struct packed {
        logic [10:0] load_position;
        logic [1:0]  error_code;
    } t_out_item;

endpackage

// ===== hw/rtl/threshold_keyed_rank_sorter_top.sv =====
// channel   direction  handshake                    payload
// input     in         i_in_valid / o_in_stall      i_in_data  (t_in_item)
// output    out        o_out_valid / i_out_stall    o_out_data (t_out_item)
// config    in         i_cfg_we                     i_cfg_data (primary_threshold)
//
// clear and load update the store from idle; a query on a ranked store goes through
// the order memory read, then the result register.
// a query after any accepted load, clear or threshold write first runs an insertion
// sort over the memories: an identity fill, then per record a key fetch and compares.
// reset is synchronous active low and clears count, ranked flag and output valid.
// input stalls while a query or sort runs, or while a result waits on i_out_stall.
module threshold_keyed_rank_sorter_top
    import tkrs_pkg::*;
#(
    parameter int MAX_RECORDS = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  t_in_item        i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output t_out_item       o_out_data,
    input  logic            i_cfg_we,
    input  logic [31:0]     i_cfg_data
);

    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int KW = KEY_WIDTH;

    typedef struct packed {
        logic [KW-1:0] p;
        logic [KW-1:0] s;
        logic [KW-1:0] t;
    } t_keys;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CUR_O, S_CUR_K, S_CUR_L,
        S_CMP_O, S_CMP_K, S_CMP, S_PLACE, S_Q, S_QD
    } t_state;

    // memories
    t_keys           key_mem [MAX_RECORDS];
    logic [IW-1:0]   ord_mem [MAX_RECORDS];

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic            r_sorted, n_sorted;
    logic [KW-1:0]   r_thr;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_j, n_j;
    logic [10:0]     r_rank, n_rank;
    logic [IW-1:0]   r_cur_idx, n_cur_idx;
    t_keys           r_cur_key, n_cur_key;
    logic [IW-1:0]   r_o_idx, n_o_idx;
    logic            r_out_valid, n_out_valid;
    t_out_item       r_out, n_out;
    t_keys           r_key_rd;
    logic [IW-1:0]   r_ord_rd;

    logic            accept;
    logic            key_we;
    logic [IW-1:0]   key_raddr;
    logic            ord_we;
    logic [IW-1:0]   ord_waddr, ord_wdata, ord_raddr;
    logic            cur_ahead;

    // record a (current) ranks ahead of record b
    function automatic logic ranks_before(t_keys a, logic [IW-1:0] ai,
                                          t_keys b, logic [IW-1:0] bi,
                                          logic [KW-1:0] thr);
        logic res;
        if (a.p != b.p) begin
            res = a.p > b.p;
        end else if (a.p >= thr) begin
            res = (a.t != b.t) ? (a.t > b.t) : (ai < bi);
        end else begin
            res = (a.s != b.s) ? (a.s > b.s) : (ai < bi);
        end
        return res;
    endfunction

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign cur_ahead   = ranks_before(r_cur_key, r_cur_idx, r_key_rd, r_o_idx, r_thr);

    // key memory: load writes, sort reads
    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[r_count[IW-1:0]] <= '{p: KW'(i_in_data.primary_key),
                                          s: KW'(i_in_data.second_key),
                                          t: KW'(i_in_data.third_key)};
        end
        r_key_rd <= key_mem[key_raddr];
    end

    // order memory: rank to load slot
    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            ord_mem[ord_waddr] <= ord_wdata;
        end
        r_ord_rd <= ord_mem[ord_raddr];
    end

    // next state and memory control
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_sorted    = r_sorted;
        n_i         = r_i;
        n_j         = r_j;
        n_rank      = r_rank;
        n_cur_idx   = r_cur_idx;
        n_cur_key   = r_cur_key;
        n_o_idx     = r_o_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        key_we      = 1'b0;
        key_raddr   = r_ord_rd;
        ord_we      = 1'b0;
        ord_waddr   = r_j[IW-1:0];
        ord_wdata   = r_cur_idx;
        ord_raddr   = r_i[IW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_data.command)
                        CMD_CLEAR: begin
                            n_count  = '0;
                            n_sorted = 1'b0;
                        end
                        CMD_LOAD: begin
                            if (r_count == CW'(MAX_RECORDS)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{load_position: '0, error_code: ERR_FULL};
                            end else begin
                                key_we   = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_sorted = 1'b0;
                            end
                        end
                        CMD_QUERY: begin
                            if (i_in_data.rank_asked == '0 ||
                                32'(i_in_data.rank_asked) > 32'(r_count)) begin
                                n_out_valid = 1'b1;
                                n_out       = '{load_position: '0, error_code: ERR_RANK};
                            end else begin
                                n_rank  = i_in_data.rank_asked;
                                n_i     = '0;
                                n_state = r_sorted ? S_Q : S_INIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // identity fill of the order memory
            S_INIT: begin
                ord_we    = 1'b1;
                ord_waddr = r_i[IW-1:0];
                ord_wdata = r_i[IW-1:0];
                if (r_i + 1'b1 >= r_count) begin
                    n_i = CW'(1);
                    if (r_count > CW'(1)) begin
                        n_state = S_CUR_O;
                    end else begin
                        n_sorted = 1'b1;
                        n_state  = S_Q;
                    end
                end else begin
                    n_i = r_i + 1'b1;
                end
            end
            S_CUR_O: begin
                ord_raddr = r_i[IW-1:0];
                n_state   = S_CUR_K;
            end
            S_CUR_K: begin
                n_cur_idx = r_ord_rd;
                n_state   = S_CUR_L;
            end
            S_CUR_L: begin
                n_cur_key = r_key_rd;
                n_j       = r_i;
                n_state   = S_CMP_O;
            end
            S_CMP_O: begin
                ord_raddr = IW'(r_j - 1'b1);
                n_state   = S_CMP_K;
            end
            S_CMP_K: begin
                n_o_idx = r_ord_rd;
                n_state = S_CMP;
            end
            // shift the neighbor up while the current record ranks ahead
            S_CMP: begin
                if (cur_ahead) begin
                    ord_we    = 1'b1;
                    ord_wdata = r_o_idx;
                    n_j       = r_j - 1'b1;
                    n_state   = (r_j == CW'(1)) ? S_PLACE : S_CMP_O;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                ord_we    = 1'b1;
                ord_wdata = r_cur_idx;
                n_i       = r_i + 1'b1;
                if (r_i + 1'b1 >= r_count) begin
                    n_sorted = 1'b1;
                    n_state  = S_Q;
                end else begin
                    n_state = S_CUR_O;
                end
            end
            S_Q: begin
                ord_raddr = IW'(r_rank - 1'b1);
                n_state   = S_QD;
            end
            S_QD: begin
                n_out_valid = 1'b1;
                n_out       = '{load_position: 11'(r_ord_rd) + 11'd1, error_code: ERR_OK};
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        // threshold write marks the ranking stale
        if (i_cfg_we) begin
            n_sorted = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_sorted    <= 1'b0;
            r_thr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sorted    <= n_sorted;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_thr <= KW'(i_cfg_data);
            end
        end
        r_i       <= n_i;
        r_j       <= n_j;
        r_rank    <= n_rank;
        r_cur_idx <= n_cur_idx;
        r_cur_key <= n_cur_key;
        r_o_idx   <= n_o_idx;
        r_out     <= n_out;
    end

endmodule

// ===== hw/rtl/tkrs_checker.sv =====
`include "threshold_keyed_rank_sorter_top_macros.svh"

module tkrs_checker
    import tkrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        o_in_stall,
    input  t_in_item    i_in_data,
    input  logic        o_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   o_out_data,
    input  logic        i_cfg_we
);

    logic out_err;
    logic cfg_quiet;

    // error result and quiet block for threshold writes
    assign out_err   = o_out_valid && (o_out_data.error_code != ERR_OK);
    assign cfg_quiet = !i_in_valid && !o_in_stall && !o_out_valid;

    // a stalled result holds
    `TKRS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))
    // a stalled input transaction holds
    `TKRS_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_data))
    // an error result carries no position
    `TKRS_ASSERT_IMPL(a_err_pos, i_clk, i_rst_n, out_err, o_out_data.load_position == '0)
    // threshold writes only while nothing is in flight
    `TKRS_ASSERT_IMPL(a_cfg_idle, i_clk, i_rst_n, i_cfg_we, cfg_quiet)
    // reset drops any pending result
    `TKRS_ASSERT_ALWAYS_NEXT(a_rst_out, i_clk, !i_rst_n, !o_out_valid)

endmodule

bind threshold_keyed_rank_sorter_top tkrs_checker u_tkrs_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import tkrs_pkg::*;

    localparam int STORE_DEPTH = 1024;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;
    logic      i_cfg_we;
    logic [31:0] i_cfg_data;

    // sorter model state
    logic [31:0] sort_threshold;
    logic [31:0] pri_keys [STORE_DEPTH];
    logic [31:0] sec_keys [STORE_DEPTH];
    logic [31:0] ter_keys [STORE_DEPTH];
    int          rank_order [STORE_DEPTH];
    int          stored_count;
    bit          ranking_fresh;

    t_in_item  pending_items [$];
    t_out_item expected_results [$];

    int  error_count;
    int  result_count;
    int  accepted_count;
    int  full_hits;
    int  rank_errors;
    int  cycle_count;
    int  send_gap;
    int  recv_wait;
    int  recv_hold;
    bit  idle_gaps_on;
    bit  long_hold_req;

    threshold_keyed_rank_sorter_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // true when slot a ranks ahead of slot b
    function automatic bit ranks_ahead(int a, int b);
        if (pri_keys[a] != pri_keys[b]) return pri_keys[a] > pri_keys[b];
        if (pri_keys[a] >= sort_threshold) begin
            if (ter_keys[a] != ter_keys[b]) return ter_keys[a] > ter_keys[b];
        end else begin
            if (sec_keys[a] != sec_keys[b]) return sec_keys[a] > sec_keys[b];
        end
        return a < b;
    endfunction

    // stable insertion sort of the load slots
    function automatic void rebuild_ranking();
        int cur;
        int j;
        for (int i = 0; i < stored_count; i++) rank_order[i] = i;
        for (int i = 1; i < stored_count; i++) begin
            cur = rank_order[i];
            j = i;
            while (j > 0 && ranks_ahead(cur, rank_order[j-1])) begin
                rank_order[j] = rank_order[j-1];
                j--;
            end
            rank_order[j] = cur;
        end
        ranking_fresh = 1'b1;
    endfunction

    // apply one accepted transaction to the model
    function automatic void predict_sorter(t_in_item it);
        t_out_item res;
        case (it.command)
            CMD_CLEAR: begin
                stored_count = 0;
                ranking_fresh = 1'b0;
            end
            CMD_LOAD: begin
                if (stored_count >= STORE_DEPTH) begin
                    res.load_position = '0;
                    res.error_code = ERR_FULL;
                    expected_results.push_back(res);
                end else begin
                    pri_keys[stored_count] = it.primary_key;
                    sec_keys[stored_count] = it.second_key;
                    ter_keys[stored_count] = it.third_key;
                    stored_count++;
                    ranking_fresh = 1'b0;
                end
            end
            CMD_QUERY: begin
                if (it.rank_asked == 0 || it.rank_asked > stored_count) begin
                    res.load_position = '0;
                    res.error_code = ERR_RANK;
                end else begin
                    if (!ranking_fresh) rebuild_ranking();
                    res.load_position = 11'(rank_order[it.rank_asked - 1] + 1);
                    res.error_code = ERR_OK;
                end
                expected_results.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // input driver
    always @(posedge i_clk) begin
        bit holding;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = 0;
        end else begin
            holding = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                predict_sorter(i_in_data);
                accepted_count++;
                holding = 1'b0;
            end
            if (!holding) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    i_in_data <= pending_items.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = idle_gaps_on ? $urandom_range(0, 5) : 0;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stall
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_wait = 0;
            recv_hold = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                result_count++;
                if (expected_results.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, actual pos=%0d err=%0d",
                             $time, o_out_data.load_position, o_out_data.error_code);
                end else begin
                    want = expected_results.pop_front();
                    if (want.error_code == ERR_FULL) full_hits++;
                    if (want.error_code == ERR_RANK) rank_errors++;
                    if (o_out_data.load_position !== want.load_position) begin
                        error_count++;
                        $display("%0t: load_position mismatch, expected %0d actual %0d",
                                 $time, want.load_position, o_out_data.load_position);
                    end
                    if (o_out_data.error_code !== want.error_code) begin
                        error_count++;
                        $display("%0t: error_code mismatch, expected %0d actual %0d",
                                 $time, want.error_code, o_out_data.error_code);
                    end
                end
                recv_wait = idle_gaps_on ? $urandom_range(0, 5) : 0;
            end
            if (long_hold_req) begin
                recv_hold = 300;
                long_hold_req = 1'b0;
            end
            if (recv_hold > 0) begin
                recv_hold--;
                i_out_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", expected_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic void push_item(logic [1:0] cmd, logic [31:0] pk, logic [31:0] sk,
                                      logic [31:0] tk, logic [10:0] rank);
        t_in_item it;
        it.command = cmd;
        it.primary_key = pk;
        it.second_key = sk;
        it.third_key = tk;
        it.rank_asked = rank;
        pending_items.push_back(it);
    endfunction

    // key drawn mostly from a tiny range so ties and threshold edges are common
    function automatic logic [31:0] draw_key();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            default: return $urandom_range(0, 4);
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sort_threshold = value;
        ranking_fresh = 1'b0;
    endtask

    // one clear-load-query sequence with random content
    task automatic add_sequence();
        int loads;
        int queries;
        loads = $urandom_range(1, 24);
        push_item(CMD_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
        for (int i = 0; i < loads; i++)
            push_item(CMD_LOAD, draw_key(), draw_key(), draw_key(), $urandom());
        queries = $urandom_range(2, 8);
        for (int i = 0; i < queries; i++)
            push_item(CMD_QUERY, $urandom(), $urandom(), $urandom(),
                      11'($urandom_range(1, loads)));
        // occasional noise: bad ranks, ignored command, extra loads
        case ($urandom_range(0, 5))
            0: push_item(CMD_QUERY, $urandom(), $urandom(), $urandom(), 11'($urandom()));
            1: push_item(2'd3, $urandom(), $urandom(), $urandom(), $urandom());
            2: begin
                push_item(CMD_LOAD, draw_key(), draw_key(), draw_key(), $urandom());
                push_item(CMD_QUERY, $urandom(), $urandom(), $urandom(),
                          11'($urandom_range(0, loads + 2)));
            end
            default: ;
        endcase
    endtask

    // stimulus
    initial begin
        logic [31:0] thresholds [5];
        error_count = 0;
        result_count = 0;
        accepted_count = 0;
        full_hits = 0;
        rank_errors = 0;
        cycle_count = 0;
        idle_gaps_on = 1'b1;
        long_hold_req = 1'b0;
        sort_threshold = '0;
        stored_count = 0;
        ranking_fresh = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty store, ignored command, extreme keys and ranks
        push_item(CMD_QUERY, '0, '0, '0, 11'd1);
        push_item(2'd3, '1, '1, '1, '1);
        push_item(CMD_LOAD, '0, '0, '0, '0);
        push_item(CMD_LOAD, '1, '0, '1, '1);
        push_item(CMD_LOAD, '1, '1, '0, '0);
        push_item(CMD_LOAD, '0, '1, '0, '0);
        push_item(CMD_LOAD, '1, '0, '1, '0);
        for (int r = 1; r <= 5; r++) push_item(CMD_QUERY, '0, '0, '0, 11'(r));
        push_item(CMD_QUERY, '1, '1, '1, 11'd0);
        push_item(CMD_QUERY, '0, '0, '0, 11'd6);
        push_item(CMD_QUERY, '0, '0, '0, 11'h7FF);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1024);
        push_item(CMD_CLEAR, '1, '1, '1, '1);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1);
        wait_idle();

        // queries on the empty store, then new records under the top threshold
        write_threshold(32'hFFFF_FFFF);
        for (int r = 1; r <= 3; r++) push_item(CMD_QUERY, '0, '0, '0, 11'(r));
        push_item(CMD_LOAD, '0, '0, '0, '0);
        push_item(CMD_LOAD, '1, '1, '1, '0);
        push_item(CMD_LOAD, '1, '0, '1, '0);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1);
        push_item(CMD_QUERY, '0, '0, '0, 11'd2);
        wait_idle();

        // fill to capacity in rank order so the sort does no shifting
        idle_gaps_on = 1'b0;
        write_threshold(32'd0);
        push_item(CMD_CLEAR, '0, '0, '0, '0);
        for (int i = 0; i < STORE_DEPTH; i++)
            push_item(CMD_LOAD, 32'(5000 - i), $urandom(), $urandom(), '0);
        for (int i = 0; i < 3; i++)
            push_item(CMD_LOAD, $urandom(), $urandom(), $urandom(), '0);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1024);
        push_item(CMD_QUERY, '0, '0, '0, 11'd1025);
        push_item(CMD_QUERY, '0, '0, '0, 11'd512);
        push_item(CMD_CLEAR, '0, '0, '0, '0);
        wait_idle();

        // random phases across several thresholds
        thresholds[0] = 32'd0;
        thresholds[1] = 32'd2;
        thresholds[2] = 32'hFFFF_FFFF;
        thresholds[3] = 32'hFFFF_FFFE;
        thresholds[4] = 32'd3;
        for (int ph = 0; ph < 10; ph++) begin
            write_threshold(ph < 5 ? thresholds[ph] : (ph == 7 ? $urandom() : 32'(
                            $urandom_range(0, 5))));
            idle_gaps_on = (ph % 3 != 2);
            if (ph == 4) long_hold_req = 1'b1;
            while (pending_items.size() < 60) add_sequence();
            wait_idle();
        end

        $display("%0d transactions accepted, %0d results checked (%0d rank errors, %0d full)",
                 accepted_count, result_count, rank_errors, full_hits);
        $display("covered ten threshold settings, a full store and a long output hold-off");
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tkrs_pkg.sv
hw/rtl/threshold_keyed_rank_sorter_top.sv
hw/rtl/tkrs_checker.sv
tb/tb.sv
